// ----- sv/terg_pkg.sv -----
package terg_pkg;

   // Width of the decay factor register as seen on the configuration port
   localparam int DECAY_WIDTH = 16;

   // Decay factor after reset, about 0.990 in unsigned Q0.16
   localparam logic [DECAY_WIDTH-1:0] DECAY_RESET = 16'd64884;

   // Ramp ends once d < DONE_NUM / DONE_DEN, that is d * DONE_DEN < DONE_NUM * 1.0
   localparam int DONE_NUM = 5;
   localparam int DONE_DEN = 1000;
   localparam int DONE_DEN_BITS = 10;

   // Ramp markers carried with each request
   typedef struct packed {
      logic up;
      logic down;
   } mark_type;

endpackage

// ----- sv/terg_req_if.sv -----
interface terg_req_if #(
   parameter int SAMPLE_WIDTH = 16
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_i;
   logic signed [SAMPLE_WIDTH-1:0] sample_q;
   logic                           ramp_up_mark;
   logic                           ramp_down_mark;

   modport source (
      output valid, sample_i, sample_q, ramp_up_mark, ramp_down_mark,
      input  ready
   );

   modport sink (
      input  valid, sample_i, sample_q, ramp_up_mark, ramp_down_mark,
      output ready
   );
endinterface

// ----- sv/terg_rsp_if.sv -----
interface terg_rsp_if #(
   parameter int SAMPLE_WIDTH = 16
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] out_i;
   logic signed [SAMPLE_WIDTH-1:0] out_q;

   modport source (
      output valid, out_i, out_q,
      input  ready
   );

   modport sink (
      input  valid, out_i, out_q,
      output ready
   );
endinterface

// ----- sv/terg_envelope.sv -----
module terg_envelope #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       csr_write_enable,
   input  logic [terg_pkg::DECAY_WIDTH-1:0]           csr_write_data,
   input  logic                                       accept,
   input  terg_pkg::mark_type                         marks,
   output logic [FRAC_BITS:0]                         gain
);

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_UP   = 2'd1,
      MODE_DOWN = 2'd2
   } mode_type;

   localparam int GW = FRAC_BITS + 1;
   localparam int SW = FRAC_BITS + 1 + terg_pkg::DONE_DEN_BITS;
   localparam int PW = 2 * FRAC_BITS + 1;
   localparam logic [GW-1:0] ONE_Q = GW'(1) << FRAC_BITS;
   localparam logic [SW-1:0] DONE_LIMIT = SW'(terg_pkg::DONE_NUM) << FRAC_BITS;

   mode_type                           mode_ff, mode_in;
   logic [GW-1:0]                      env_ff, env_in;
   logic [GW-1:0]                      gain_ff, gain_in;
   logic [terg_pkg::DECAY_WIDTH-1:0]   decay_ff, decay_in;

   mode_type                           mode_eff;
   logic [GW-1:0]                      d;
   logic [FRAC_BITS-1:0]               decay_q;
   logic [SW-1:0]                      d_scaled;
   logic                               done;
   logic [PW-1:0]                      decay_prod;

   // Use only the fractional bits of the decay register
   assign decay_q = FRAC_BITS'(decay_ff);

   // Pick the mode for this request: start a ramp from idle, up wins
   always_comb begin
      mode_eff = MODE_IDLE;
      d        = env_ff;
      case (mode_ff)
         MODE_UP, MODE_DOWN: begin
            mode_eff = mode_ff;
         end
         default: begin
            d = ONE_Q;
            if (marks.up) begin
               mode_eff = MODE_UP;
            end else if (marks.down) begin
               mode_eff = MODE_DOWN;
            end else begin
               mode_eff = MODE_IDLE;
               d        = env_ff;
            end
         end
      endcase
   end

   // End-of-ramp test and envelope decay
   assign d_scaled   = SW'(d) * SW'(terg_pkg::DONE_DEN);
   assign done       = d_scaled < DONE_LIMIT;
   assign decay_prod = PW'(d) * PW'(decay_q);

   // Advance gain, envelope and mode on each accepted request; load the decay factor on a CSR write
   always_comb begin
      mode_in  = mode_ff;
      env_in   = env_ff;
      gain_in  = gain_ff;
      decay_in = decay_ff;
      if (csr_write_enable) begin
         decay_in = csr_write_data;
      end
      if (accept) begin
         mode_in = mode_eff;
         case (mode_eff)
            MODE_UP: begin
               gain_in = done ? ONE_Q : ONE_Q - d;
               env_in  = decay_prod[FRAC_BITS +: GW];
               if (done) begin
                  mode_in = MODE_IDLE;
               end
            end
            MODE_DOWN: begin
               gain_in = done ? '0 : d;
               env_in  = decay_prod[FRAC_BITS +: GW];
               if (done) begin
                  mode_in = MODE_IDLE;
               end
            end
            default: begin
               mode_in = MODE_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         env_ff   <= ONE_Q;
         gain_ff  <= '0;
         decay_ff <= terg_pkg::DECAY_RESET;
      end else begin
         mode_ff  <= mode_in;
         env_ff   <= env_in;
         gain_ff  <= gain_in;
         decay_ff <= decay_in;
      end
   end

   assign gain = gain_ff;

endmodule

// ----- sv/tagged_exponential_ramp_gain_core.sv -----
// Tagged exponential ramp gain.
// Requests arrive on req_port (valid/ready): a complex sample and two marker
// bits. A ramp-up marker seen while idle starts a rising gain 1 - d, a
// ramp-down marker a falling gain d; d starts at 1.0 and is multiplied by
// the decay factor each sample. Below 0.005 the gain snaps to 1.0 or 0.
// Markers during a ramp are ignored. Each sample leaves on rsp_port scaled
// by the gain, floor of x * gain / 2^FRAC_BITS.
// The decay factor is written through csr_write_enable / csr_write_data; the
// user must write it only while the block is idle, which the block does not
// enforce. It takes effect from the next request. After acceptance one
// register holds the sample with its gain, then another the scaled product.
// Throughput is one request per cycle; a new request is accepted every cycle
// as long as the output register empties or is about to.
// When rsp_port.ready is low the result holds, the middle stage fills and
// then req_port.ready drops; nothing is lost or repeated.
// Reset clears both stages, sets the gain to 0, the mode to idle and the
// decay factor to 64884 (about 0.990).
module tagged_exponential_ramp_gain_core #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int FRAC_BITS    = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   terg_req_if.sink                            req_port,
   terg_rsp_if.source                          rsp_port,
   input  logic                                csr_write_enable,
   input  logic [terg_pkg::DECAY_WIDTH-1:0]    csr_write_data
);

   localparam int GW = FRAC_BITS + 1;
   localparam int PW = SAMPLE_WIDTH + FRAC_BITS + 2;

   logic                           accept;
   logic                           adv_out;
   terg_pkg::mark_type             marks;
   logic [GW-1:0]                  gain;

   logic                           s1_valid_ff, s1_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] s1_i_ff, s1_i_in;
   logic signed [SAMPLE_WIDTH-1:0] s1_q_ff, s1_q_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] out_i_ff, out_i_in;
   logic signed [SAMPLE_WIDTH-1:0] out_q_ff, out_q_in;

   logic signed [PW-1:0]           gain_ext;
   logic signed [PW-1:0]           prod_i;
   logic signed [PW-1:0]           prod_q;

   // Handshake: the output register empties or is empty, the middle stage follows
   assign adv_out        = !rsp_valid_ff || rsp_port.ready;
   assign req_port.ready = !s1_valid_ff || adv_out;
   assign accept         = req_port.valid && req_port.ready;

   assign marks = '{up: req_port.ramp_up_mark, down: req_port.ramp_down_mark};

   // Gain for the accepted request is registered alongside its sample
   terg_envelope #(
      .FRAC_BITS (FRAC_BITS)
   ) u_envelope (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .accept           (accept),
      .marks            (marks),
      .gain             (gain)
   );

   // Scale the held sample by its gain, floor by arithmetic truncation
   assign gain_ext = signed'({{(PW-GW){1'b0}}, gain});
   assign prod_i   = signed'({{(PW-SAMPLE_WIDTH){s1_i_ff[SAMPLE_WIDTH-1]}}, s1_i_ff}) * gain_ext;
   assign prod_q   = signed'({{(PW-SAMPLE_WIDTH){s1_q_ff[SAMPLE_WIDTH-1]}}, s1_q_ff}) * gain_ext;

   // Advance the two stages
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_i_in      = s1_i_ff;
      s1_q_in      = s1_q_ff;
      rsp_valid_in = rsp_valid_ff;
      out_i_in     = out_i_ff;
      out_q_in     = out_q_ff;
      if (adv_out) begin
         rsp_valid_in = s1_valid_ff;
         out_i_in     = prod_i[FRAC_BITS +: SAMPLE_WIDTH];
         out_q_in     = prod_q[FRAC_BITS +: SAMPLE_WIDTH];
         s1_valid_in  = 1'b0;
      end
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_i_in     = req_port.sample_i;
         s1_q_in     = req_port.sample_q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold payload without reset
   always_ff @(posedge clock) begin
      s1_i_ff  <= s1_i_in;
      s1_q_ff  <= s1_q_in;
      out_i_ff <= out_i_in;
      out_q_ff <= out_q_in;
   end

   assign rsp_port.valid = rsp_valid_ff;
   assign rsp_port.out_i = out_i_ff;
   assign rsp_port.out_q = out_q_ff;

endmodule
